// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the flanger RTL.
// Each macro wraps one clocked concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/lfo_pkg.sv =====
// ----------------------------------------------------------------------------
// lfo_pkg
// Sizes, register indexes, fixed-point constants and the quarter-wave sine
// table of the LFO-modulated flanger.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_pkg;

   localparam int DELAY_ENTRIES = 128;
   localparam int SINE_ENTRIES  = 1024;

   localparam int PTR_W        = $clog2(DELAY_ENTRIES);
   localparam int SINE_W       = $clog2(SINE_ENTRIES);
   localparam int QTR_W        = SINE_W - 2;
   localparam int SINE_QUARTER = SINE_ENTRIES / 4;

   localparam int SAMPLE_W    = 16;
   localparam int KNOB_W      = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int DLY_W       = 7;
   localparam int DLY_MAX     = 95;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [PTR_W:0]   ptr_wide_type;
   typedef logic [KNOB_W-1:0] knob_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX      = 2'd3;

   // Sine quadrants
   localparam logic [1:0] QUAD_RISE     = 2'd0;
   localparam logic [1:0] QUAD_FALL     = 2'd1;
   localparam logic [1:0] QUAD_NEG_FALL = 2'd2;
   localparam logic [1:0] QUAD_NEG_RISE = 2'd3;

   // Phase increment: floor((8192*rate + 62) / 125) by reciprocal, exact below 2^25.
   localparam logic [24:0] INC_OFFSET = 25'd62;
   localparam logic [25:0] INC_RECIP  = 26'd34359739;

   // Coefficients: floor((knob*scale + 5) / 10) by reciprocal, exact below 2^22.
   localparam logic [19:0] FB_SCALE    = 20'd96;
   localparam logic [19:0] MIX_SCALE   = 20'd192;
   localparam logic [19:0] COEF_ROUND  = 20'd5;
   localparam logic [19:0] TENTH_RECIP = 20'd838861;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic [14:0] sine_mag_type;
   typedef sine_mag_type sine_table_type [SINE_QUARTER];

   // Magnitude of the Q1.15 sine at entry j of the first quadrant, from an
   // odd Taylor series in Q30.
   function automatic sine_mag_type sine_quarter_entry(input int unsigned j);
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      u    = (64'(j) << 32) / SINE_ENTRIES;
      x    = (u * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      sum  = (sum + 64'd16384) >> 15;
      if (sum > 64'd32767) begin
         sum = 64'd32767;
      end
      return sum[14:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      for (int unsigned i = 0; i < SINE_QUARTER; i++) begin
         tbl[i] = sine_quarter_entry(i);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam sine_mag_type   SINE_PEAK  = sine_quarter_entry(SINE_QUARTER);

   // LFO level in Q0.16: one half plus half the sine of table entry k.
   function automatic logic [15:0] lfo_level(input logic [SINE_W-1:0] k);
      logic [1:0]       quad;
      logic [QTR_W-1:0] j;
      logic [QTR_W-1:0] jn;
      sine_mag_type     mag;
      logic             neg;
      quad = k[SINE_W-1 -: 2];
      j    = k[QTR_W-1:0];
      jn   = {QTR_W{1'b0}} - j;
      case (quad)
         QUAD_RISE: begin
            mag = SINE_TABLE[j];
            neg = 1'b0;
         end
         QUAD_FALL: begin
            mag = (j == '0) ? SINE_PEAK : SINE_TABLE[jn];
            neg = 1'b0;
         end
         QUAD_NEG_FALL: begin
            mag = SINE_TABLE[j];
            neg = 1'b1;
         end
         default: begin
            mag = (j == '0) ? SINE_PEAK : SINE_TABLE[jn];
            neg = 1'b1;
         end
      endcase
      return neg ? (16'h8000 - {1'b0, mag}) : (16'h8000 + {1'b0, mag});
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lfo_req_if.sv =====
// ----------------------------------------------------------------------------
// lfo_req_if
// Input channel of the flanger: one audio sample and its frame-start flag
// per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfo_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  frame_start;
   logic signed [lfo_pkg::SAMPLE_W-1:0]   in_sample;

   modport source (output valid, output frame_start, output in_sample, input ready);
   modport sink   (input valid, input frame_start, input in_sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfo_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfo_rsp_if
// Result channel of the flanger: one flanged sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfo_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [lfo_pkg::SAMPLE_W-1:0]   out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfo_ram.sv =====
// ----------------------------------------------------------------------------
// lfo_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lfo_flanger.sv =====
// ----------------------------------------------------------------------------
// lfo_flanger
// Sine-LFO modulated short-delay flanger with a one-pole smoother on the
// delayed signal and a saturated wet/dry mix.
// ----------------------------------------------------------------------------
//
//   channel   direction   beat contents
//   req_chan  in          frame_start, in_sample
//   rsp_chan  out         out_sample
//   csr_*     in          csr_we, csr_index, csr_wdata (write only)
//
// An accepted sample passes through the busy states DLY, RD, SM1, SM2,
// OUT1 and OUT2 of the sequencer on its way to the output register; the
// next sample is taken only once the sequencer is back in idle.
// The delay line sits in a RAM with a registered read; a fill flag marks
// when every entry has been written, so reset takes effect at once.
// A stalled output holds the sequencer in its last state; a new sample is
// still taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfo_flanger (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lfo_req_if.sink                                  req_chan,
   lfo_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [lfo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lfo_pkg::KNOB_W-1:0]          csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DLY  = 7'b0000010,
      S_RD   = 7'b0000100,
      S_SM1  = 7'b0001000,
      S_SM2  = 7'b0010000,
      S_OUT1 = 7'b0100000,
      S_OUT2 = 7'b1000000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   lfo_pkg::knob_type depth_ff, depth_in;
   lfo_pkg::knob_type rate_ff, rate_in;
   lfo_pkg::knob_type feedback_ff, feedback_in;
   lfo_pkg::knob_type mix_ff, mix_in;

   logic [31:0]                          phase_ff, phase_in;
   lfo_pkg::ptr_type                     wp_ff, wp_in;
   logic                                 filled_ff, filled_in;
   logic signed [31:0]                   s_ff, s_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic signed [lfo_pkg::SAMPLE_W-1:0]  x_ff, x_in;
   logic                                 fs_ff, fs_in;
   logic [15:0]                          lfo_ff, lfo_in;
   logic [lfo_pkg::DLY_W-1:0]            dly_ff, dly_in;
   logic [15:0]                          f_ff, f_in;
   logic [16:0]                          m_ff, m_in;
   logic                                 rd_valid_ff, rd_valid_in;
   logic signed [31:0]                   prod_f_ff, prod_f_in;
   logic signed [49:0]                   prod_g_ff, prod_g_in;
   logic signed [33:0]                   pa_ff, pa_in;
   logic signed [49:0]                   pb_ff, pb_in;
   logic signed [lfo_pkg::SAMPLE_W-1:0]  out_sample_ff, out_sample_in;

   logic                                 req_accept;
   logic                                 rsp_accept;
   logic [15:0]                          lfo_now;
   logic [27:0]                          dly_prod;
   logic [29:0]                          dly_x3;
   logic [24:0]                          inc_w;
   logic [50:0]                          inc_prod;
   logic [19:0]                          f_v;
   logic [19:0]                          m_v;
   logic [39:0]                          f_prod;
   logic [39:0]                          m_prod;
   lfo_pkg::ptr_wide_type                rd_wide;
   lfo_pkg::ptr_type                     rd_addr;
   logic [lfo_pkg::SAMPLE_W-1:0]         ram_q;
   logic signed [lfo_pkg::SAMPLE_W-1:0]  delayed;
   logic signed [31:0]                   s_eff;
   logic signed [16:0]                   f_s;
   logic signed [17:0]                   g_s;
   logic signed [17:0]                   m_s;
   logic signed [17:0]                   gm_s;
   logic signed [32:0]                   prod_f_full;
   logic signed [49:0]                   s_sum;
   logic signed [51:0]                   acc;
   logic signed [51:0]                   acc_adj;
   logic signed [19:0]                   y_full;

   assign req_accept = req_chan.valid & req_chan.ready;
   assign rsp_accept = rsp_valid_ff & rsp_chan.ready;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = out_sample_ff;

   // Datapath terms, each used by one state of the sequencer.
   assign lfo_now  = lfo_pkg::lfo_level(phase_ff[31 -: lfo_pkg::SINE_W]);
   assign dly_prod = 28'(depth_ff) * 28'(lfo_ff);
   assign dly_x3   = {2'b00, dly_prod} + {1'b0, dly_prod, 1'b0};
   assign inc_w    = {rate_ff, 13'd0} + lfo_pkg::INC_OFFSET;
   assign inc_prod = 51'(inc_w) * 51'(lfo_pkg::INC_RECIP);
   assign f_v      = 20'(feedback_ff) * lfo_pkg::FB_SCALE + lfo_pkg::COEF_ROUND;
   assign m_v      = 20'(mix_ff) * lfo_pkg::MIX_SCALE + lfo_pkg::COEF_ROUND;
   assign f_prod   = 40'(f_v) * 40'(lfo_pkg::TENTH_RECIP);
   assign m_prod   = 40'(m_v) * 40'(lfo_pkg::TENTH_RECIP);

   // Read pointer trails the write pointer by the delay, wrapping round.
   always_comb begin
      rd_wide = {1'b0, wp_ff} - lfo_pkg::ptr_wide_type'(dly_ff);
      if (wp_ff < lfo_pkg::ptr_type'(dly_ff)) begin
         rd_wide = rd_wide + lfo_pkg::ptr_wide_type'(lfo_pkg::DELAY_ENTRIES);
      end
   end
   assign rd_addr = rd_wide[lfo_pkg::PTR_W-1:0];

   assign delayed     = rd_valid_ff ? $signed(ram_q) : '0;
   assign s_eff       = fs_ff ? '0 : s_ff;
   assign f_s         = $signed({1'b0, f_ff});
   assign g_s         = 18'sd65536 - $signed({2'b00, f_ff});
   assign m_s         = $signed({1'b0, m_ff});
   assign gm_s        = 18'sd65536 - m_s;
   assign prod_f_full = f_s * delayed;
   assign s_sum       = (prod_g_ff >>> 16) + 50'(prod_f_ff);

   // Truncation toward zero of acc / 2^32, then saturation.
   assign acc     = (52'(pa_ff) <<< 16) + 52'(pb_ff);
   assign acc_adj = acc[51] ? (acc + 52'sd4294967295) : acc;
   assign y_full  = acc_adj[51:32];

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      rate_in       = rate_ff;
      feedback_in   = feedback_ff;
      mix_in        = mix_ff;
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      filled_in     = filled_ff;
      s_in          = s_ff;
      rsp_valid_in  = rsp_valid_ff;
      x_in          = x_ff;
      fs_in         = fs_ff;
      lfo_in        = lfo_ff;
      dly_in        = dly_ff;
      f_in          = f_ff;
      m_in          = m_ff;
      rd_valid_in   = rd_valid_ff;
      prod_f_in     = prod_f_ff;
      prod_g_in     = prod_g_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      out_sample_in = out_sample_ff;

      if (csr_we) begin
         case (csr_index)
            lfo_pkg::CSR_DEPTH:    depth_in    = csr_wdata;
            lfo_pkg::CSR_RATE:     rate_in     = csr_wdata;
            lfo_pkg::CSR_FEEDBACK: feedback_in = csr_wdata;
            lfo_pkg::CSR_MIX:      mix_in      = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               x_in     = req_chan.in_sample;
               fs_in    = req_chan.frame_start;
               lfo_in   = lfo_now;
               state_in = S_DLY;
            end
         end
         S_DLY: begin
            dly_in   = dly_x3[29:23];
            phase_in = phase_ff + {13'd0, inc_prod[50:32]};
            state_in = S_RD;
         end
         S_RD: begin
            f_in        = f_prod[38:23];
            m_in        = m_prod[39:23];
            rd_valid_in = filled_ff | (rd_addr <= wp_ff);
            if (wp_ff == lfo_pkg::ptr_type'(lfo_pkg::DELAY_ENTRIES - 1)) begin
               wp_in     = '0;
               filled_in = 1'b1;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
            state_in = S_SM1;
         end
         S_SM1: begin
            prod_f_in = prod_f_full[31:0];
            prod_g_in = g_s * s_eff;
            state_in  = S_SM2;
         end
         S_SM2: begin
            s_in     = s_sum[31:0];
            state_in = S_OUT1;
         end
         S_OUT1: begin
            pa_in    = gm_s * x_ff;
            pb_in    = m_s * s_ff;
            state_in = S_OUT2;
         end
         S_OUT2: begin
            // The output register takes the result only once it is free or its result is being taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (y_full > 20'(lfo_pkg::SAMPLE_MAX)) begin
                  out_sample_in = lfo_pkg::SAMPLE_MAX;
               end else if (y_full < 20'(lfo_pkg::SAMPLE_MIN)) begin
                  out_sample_in = lfo_pkg::SAMPLE_MIN;
               end else begin
                  out_sample_in = y_full[15:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rate_ff      <= '0;
         feedback_ff  <= '0;
         mix_ff       <= '0;
         phase_ff     <= '0;
         wp_ff        <= '0;
         filled_ff    <= 1'b0;
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rate_ff      <= rate_in;
         feedback_ff  <= feedback_in;
         mix_ff       <= mix_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         filled_ff    <= filled_in;
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      fs_ff         <= fs_in;
      lfo_ff        <= lfo_in;
      dly_ff        <= dly_in;
      f_ff          <= f_in;
      m_ff          <= m_in;
      rd_valid_ff   <= rd_valid_in;
      prod_f_ff     <= prod_f_in;
      prod_g_ff     <= prod_g_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      out_sample_ff <= out_sample_in;
   end

   // The incoming sample is written at acceptance, well before its own read.
   lfo_ram #(
      .WIDTH (lfo_pkg::SAMPLE_W),
      .DEPTH (lfo_pkg::DELAY_ENTRIES)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_chan.in_sample),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   `ASSERT_NEXT(a_wp_steps, clock, reset, state_ff == S_RD, ($past(wp_ff) == lfo_pkg::ptr_type'(lfo_pkg::DELAY_ENTRIES - 1)) ? (wp_ff == '0) : (wp_ff == $past(wp_ff) + 1'b1), "write pointer did not advance by one entry")
   `ASSERT_SAME(a_fill_on_wrap, clock, reset, $rose(filled_ff), wp_ff == '0, "fill flag set without a pointer wrap")
   `ASSERT_SAME(a_delay_range, clock, reset, state_ff == S_RD, dly_ff <= lfo_pkg::DLY_MAX, "delay beyond the LFO peak")
   `ASSERT_NEXT(a_stall_holds, clock, reset, state_ff == S_OUT2 && rsp_valid_ff && !rsp_chan.ready, state_ff == S_OUT2 && $stable(pa_ff) && $stable(pb_ff), "result lost while the output was stalled")

endmodule

`default_nettype wire
